@@ design/prc_pkg.sv @@
package prc_pkg;

  localparam int PHASE_BITS_DEF   = 32;
  localparam int TUPLET_COUNT_DEF = 3;
  localparam int MAX_RATIO_DEF    = 24;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_TEMPO   = 3'd1;
  localparam logic [2:0] CFG_CVZERO  = 3'd2;
  localparam logic [2:0] CFG_CHANCE1 = 3'd3;
  localparam logic [2:0] CFG_CHANCE2 = 3'd4;
  localparam logic [2:0] CFG_CHANCE3 = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT = 3'd6;
  localparam logic [2:0] CFG_PULSE   = 3'd7;

  localparam logic [2:0]  MODE_CV    = 3'd0;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [31:0] TEMPO_RST  = 32'd178957;

  typedef struct packed {
    logic              reset_level;
    logic              toggle_level;
    logic              ext_connected;
    logic              ext_clock_level;
    logic signed [11:0] tempo_cv;
    logic [4:0]        rhythm_first;
    logic [4:0]        length_first;
    logic [4:0]        rhythm_second;
    logic [4:0]        length_second;
    logic [4:0]        rhythm_third;
    logic [4:0]        length_third;
  } prc_in_t;

  typedef struct packed {
    logic master_gate;
    logic first_gate;
    logic second_gate;
    logic third_gate;
    logic running;
  } prc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CV_MANT,
    ST_CV_SCALE,
    ST_EXT,
    ST_DIV,
    ST_EXT_SET,
    ST_LATCH,
    ST_MUL,
    ST_ADD,
    ST_WRAP,
    ST_OUT
  } prc_state_t;

  // 2^(i/16) in Q16
  function automatic logic [16:0] exp_hi(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd68438;
      4'd2:  v = 17'd71468;
      4'd3:  v = 17'd74632;
      4'd4:  v = 17'd77936;
      4'd5:  v = 17'd81386;
      4'd6:  v = 17'd84990;
      4'd7:  v = 17'd88752;
      4'd8:  v = 17'd92682;
      4'd9:  v = 17'd96785;
      4'd10: v = 17'd101070;
      4'd11: v = 17'd105545;
      4'd12: v = 17'd110218;
      4'd13: v = 17'd115098;
      4'd14: v = 17'd120194;
      4'd15: v = 17'd125515;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^(i/256) in Q16
  function automatic logic [16:0] exp_lo(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65714;
      4'd2:  v = 17'd65892;
      4'd3:  v = 17'd66071;
      4'd4:  v = 17'd66250;
      4'd5:  v = 17'd66429;
      4'd6:  v = 17'd66609;
      4'd7:  v = 17'd66790;
      4'd8:  v = 17'd66971;
      4'd9:  v = 17'd67153;
      4'd10: v = 17'd67335;
      4'd11: v = 17'd67517;
      4'd12: v = 17'd67700;
      4'd13: v = 17'd67884;
      4'd14: v = 17'd68068;
      4'd15: v = 17'd68252;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] ppqn_of(input logic [2:0] mode);
    logic [4:0] v;
    case (mode)
      3'd1:    v = 5'd2;
      3'd2:    v = 5'd4;
      3'd3:    v = 5'd8;
      3'd4:    v = 5'd12;
      default: v = 5'd24;
    endcase
    return v;
  endfunction

endpackage

@@ design/polyrhythm_clock_generator.sv @@
// Per transaction: idle, CV mantissa and scale (CV tempo mode), external clock bookkeeping,
// a divide that re-measures tempo on an external pulse, latch, then multiply, divide and add
// per tuplet, wrap and output; a stopped clock skips to output, a stalled result waits there.
// The next transaction is taken only in idle; all divisions share one serial restoring divider.
// Reset: synchronous, active low; phases zero, ratios 1/1, LFSR at its seed,
// clock stopped, registers at their documented values.
module polyrhythm_clock_generator #(
  parameter int PHASE_BITS   = prc_pkg::PHASE_BITS_DEF,
  parameter int TUPLET_COUNT = prc_pkg::TUPLET_COUNT_DEF,
  parameter int MAX_RATIO    = prc_pkg::MAX_RATIO_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  prc_pkg::prc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output prc_pkg::prc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import prc_pkg::*;

  localparam int PB  = PHASE_BITS;
  localparam int DW  = PB + 15;
  localparam int VW  = 29;
  localparam int CW  = $clog2(DW + 1);
  localparam logic [4:0]    MAXR   = 5'(MAX_RATIO > 31 ? 31 : MAX_RATIO);
  localparam logic [DW-1:0] ONE_DW = DW'(1) << PB;

  prc_state_t  state_r, state_nxt;

  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] tempo_r, tempo_nxt;
  logic [31:0] cvz_r, cvz_nxt;
  logic [8:0]  chance_r [3];
  logic [8:0]  chance_nxt [3];
  logic [23:0] timeout_r, timeout_nxt;
  logic [15:0] pulse_r, pulse_nxt;

  logic [PB:0] phase_r [4];
  logic [PB:0] phase_nxt [4];
  logic [4:0]  hn_r [3];
  logic [4:0]  hn_nxt [3];
  logic [4:0]  hd_r [3];
  logic [4:0]  hd_nxt [3];
  logic [7:0]  draw_r [3];
  logic [7:0]  draw_nxt [3];
  logic [15:0] rem_r [4];
  logic [15:0] rem_nxt [4];
  logic [15:0] lfsr_r, lfsr_nxt;
  logic        on_r, on_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [23:0] period_r, period_nxt;
  logic [PB-1:0] minc_r, minc_nxt;
  logic [2:0]  hist_r, hist_nxt;

  logic [4:0]  num_r [3];
  logic [4:0]  num_nxt [3];
  logic [4:0]  den_r [3];
  logic [4:0]  den_nxt [3];
  logic [11:0] cv_r, cv_nxt;
  logic        edge_r, edge_nxt;
  logic        extm_r, extm_nxt;
  logic [4:0]  ppqn_r, ppqn_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [14:0] pn_r, pn_nxt;
  logic [14:0] pd_r, pd_nxt;
  logic [17:0] mant_r, mant_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0] drem_r, drem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        dext_r, dext_nxt;
  prc_out_t    out_r, out_nxt;
  logic        outv_r, outv_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  always_comb begin
    logic [4:0]  n, d;
    logic [2:0]  h;
    logic        on;
    logic [11:0] u;
    logic [33:0] mp;
    logic [49:0] v, vs;
    logic [4:0]  sh;
    logic [23:0] p;
    logic [4:0]  pcn;
    logic [VW:0] t;
    logic        qb;
    logic [9:0]  lhs, rhs;
    logic [19:0] pnw, pdw;
    logic [PB:0] inc;
    logic [15:0] lf;
    logic [1:0]  kp;
    logic [4:0]  rf [3];
    logic [4:0]  lf5 [3];
    n = '0; d = '0; h = '0; on = 1'b0; u = '0; mp = '0; v = '0; vs = '0; sh = '0;
    p = '0; pcn = '0; t = '0; qb = 1'b0; lhs = '0; rhs = '0; pnw = '0; pdw = '0;
    inc = '0; lf = '0; kp = '0;
    rf[0] = in_data.rhythm_first;  lf5[0] = in_data.length_first;
    rf[1] = in_data.rhythm_second; lf5[1] = in_data.length_second;
    rf[2] = in_data.rhythm_third;  lf5[2] = in_data.length_third;

    state_nxt = state_r;
    mode_nxt = mode_r; tempo_nxt = tempo_r; cvz_nxt = cvz_r;
    timeout_nxt = timeout_r; pulse_nxt = pulse_r;
    lfsr_nxt = lfsr_r; on_nxt = on_r; pc_nxt = pc_r; period_nxt = period_r;
    minc_nxt = minc_r; hist_nxt = hist_r;
    cv_nxt = cv_r; edge_nxt = edge_r; extm_nxt = extm_r; ppqn_nxt = ppqn_r;
    k_nxt = k_r; pn_nxt = pn_r; pd_nxt = pd_r; mant_nxt = mant_r;
    dvd_nxt = dvd_r; drem_nxt = drem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    dext_nxt = dext_r; out_nxt = out_r; outv_nxt = outv_r;
    for (int i = 0; i < 3; i++) begin
      chance_nxt[i] = chance_r[i];
      hn_nxt[i] = hn_r[i]; hd_nxt[i] = hd_r[i]; draw_nxt[i] = draw_r[i];
      num_nxt[i] = num_r[i]; den_nxt[i] = den_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      phase_nxt[i] = phase_r[i];
      rem_nxt[i] = rem_r[i];
    end

    // Drop the result once taken
    if (outv_r && out_ready) outv_nxt = 1'b0;

    // Configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:    mode_nxt = cfg_data[2:0];
        CFG_TEMPO:   tempo_nxt = cfg_data;
        CFG_CVZERO:  cvz_nxt = cfg_data;
        CFG_CHANCE1: chance_nxt[0] = cfg_data[8:0];
        CFG_CHANCE2: chance_nxt[1] = cfg_data[8:0];
        CFG_CHANCE3: chance_nxt[2] = cfg_data[8:0];
        CFG_TIMEOUT: timeout_nxt = cfg_data[23:0];
        CFG_PULSE:   pulse_nxt = cfg_data[15:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          h = hist_r;
          on = on_r;
          // Edge inputs
          if (in_data.reset_level && !h[0]) begin
            for (int i = 0; i < 4; i++) phase_nxt[i] = '0;
          end
          if (in_data.toggle_level && !h[1]) on = ~on;
          h[1:0] = {in_data.toggle_level, in_data.reset_level};
          // Clamp the ratio knobs
          for (int i = 0; i < 3; i++) begin
            n = rf[i];
            d = lf5[i];
            if (n > MAXR) n = MAXR;
            if (d < 5'd1) d = 5'd1;
            if (d > MAXR) d = MAXR;
            num_nxt[i] = n;
            den_nxt[i] = d;
          end
          edge_nxt = 1'b0;
          ppqn_nxt = 5'd24;
          extm_nxt = in_data.ext_connected && (mode_r != MODE_CV);
          cv_nxt = in_data.tempo_cv;
          state_nxt = ST_EXT;
          if (in_data.ext_connected) begin
            if (mode_r == MODE_CV) begin
              state_nxt = ST_CV_MANT;
            end else begin
              edge_nxt = in_data.ext_clock_level && !h[2];
              if (in_data.ext_clock_level && !h[2]) on = 1'b1;
              h[2] = in_data.ext_clock_level;
              ppqn_nxt = ppqn_of(mode_r);
            end
          end else begin
            minc_nxt = PB'(tempo_r);
          end
          hist_nxt = h;
          on_nxt = on;
        end
      end

      // Exponential mantissa from the fractional volt
      ST_CV_MANT: begin
        u = cv_r ^ 12'h800;
        mp = 34'(exp_hi(u[7:4])) * 34'(exp_lo(u[3:0]));
        mant_nxt = mp[33:16];
        state_nxt = ST_CV_SCALE;
      end

      // Scale by the zero-volt rate and the octave, then saturate
      ST_CV_SCALE: begin
        u = cv_r ^ 12'h800;
        v = 50'(cvz_r) * 50'(mant_r);
        sh = 5'd24 - {1'b0, u[11:8]};
        vs = v >> sh;
        minc_nxt = ((vs >> PB) != '0) ? '1 : PB'(vs);
        state_nxt = ST_EXT;
      end

      // External clock bookkeeping
      ST_EXT: begin
        if (!on_r) begin
          for (int i = 0; i < 4; i++) phase_nxt[i] = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_LATCH;
          if (extm_r) begin
            p = period_r + ((period_r != 24'hFFFFFF) ? 24'd1 : 24'd0);
            if (p > timeout_r) on_nxt = 1'b0;
            period_nxt = p;
            if (edge_r) begin
              if (pc_r > 5'd1) begin
                dvs_nxt = VW'(p) * VW'(ppqn_r);
                dvd_nxt = ONE_DW;
                drem_nxt = '0;
                cnt_nxt = CW'(DW);
                dext_nxt = 1'b1;
                state_nxt = ST_DIV;
              end
              pcn = pc_r + 5'd1;
              if (pcn >= ppqn_r) pcn = '0;
              pc_nxt = pcn;
              period_nxt = '0;
            end
          end
        end
      end

      // One quotient bit per cycle
      ST_DIV: begin
        t = {drem_r, dvd_r[DW-1]};
        qb = (t >= {1'b0, dvs_r});
        drem_nxt = qb ? VW'(t - {1'b0, dvs_r}) : t[VW-1:0];
        dvd_nxt = {dvd_r[DW-2:0], qb};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) state_nxt = dext_r ? ST_EXT_SET : ST_ADD;
      end

      // Measured tempo
      ST_EXT_SET: begin
        minc_nxt = ((dvd_r >> PB) != '0) ? '1 : PB'(dvd_r);
        state_nxt = ST_LATCH;
      end

      // Take new ratios where the parent sits at zero, then advance the master
      ST_LATCH: begin
        for (int k = 0; k < TUPLET_COUNT; k++) begin
          lhs = 10'(num_r[k]) * 10'(hd_r[k]);
          rhs = 10'(hn_r[k]) * 10'(den_r[k]);
          if ((lhs != rhs) && (phase_nxt[k] == '0)) begin
            hn_nxt[k] = num_r[k];
            hd_nxt[k] = den_r[k];
            phase_nxt[k+1] = '0;
          end
        end
        phase_nxt[0] = phase_r[0] + {1'b0, minc_r};
        k_nxt = '0;
        pn_nxt = 15'd1;
        pd_nxt = 15'd1;
        state_nxt = ST_MUL;
      end

      // Extend the ratio products and start the rate division
      ST_MUL: begin
        pnw = 20'(pn_r) * 20'(hn_r[k_r]);
        pdw = 20'(pd_r) * 20'(hd_r[k_r]);
        pn_nxt = pnw[14:0];
        pd_nxt = pdw[14:0];
        dvd_nxt = DW'(minc_r) * DW'(pnw[14:0]);
        dvs_nxt = VW'(pdw[14:0]);
        drem_nxt = '0;
        cnt_nxt = CW'(DW);
        dext_nxt = 1'b0;
        state_nxt = ST_DIV;
      end

      // Advance the tuplet phase by its saturated increment
      ST_ADD: begin
        inc = (dvd_r > ONE_DW) ? ONE_DW[PB:0] : dvd_r[PB:0];
        kp = k_r + 2'd1;
        phase_nxt[kp] = phase_r[kp] + inc;
        k_nxt = kp;
        state_nxt = (32'(kp) >= 32'(TUPLET_COUNT)) ? ST_WRAP : ST_MUL;
      end

      // Wrap phases, redraw chances and start pulses
      ST_WRAP: begin
        lf = lfsr_r;
        for (int i = 0; i < 4; i++) begin
          if (i <= TUPLET_COUNT) begin
            if (phase_r[i][PB]) begin
              phase_nxt[i] = '0;
              if (i > 0) begin
                lf = lf[0] ? ((lf >> 1) ^ LFSR_TAPS) : (lf >> 1);
                draw_nxt[i-1] = lf[7:0];
              end
            end
            if (phase_nxt[i] == '0) begin
              if ((i == 0) || ({1'b0, draw_nxt[(i > 0) ? i-1 : 0]} < chance_r[(i > 0) ? i-1 : 0]))
                begin
                if (rem_r[i] < pulse_r) rem_nxt[i] = pulse_r;
              end
            end
          end
        end
        lfsr_nxt = lf;
        state_nxt = ST_OUT;
      end

      // Count down pulses and hold the result
      ST_OUT: begin
        if (!outv_r || out_ready) begin
          out_nxt.master_gate = (rem_r[0] != '0);
          out_nxt.first_gate  = (rem_r[1] != '0);
          out_nxt.second_gate = (rem_r[2] != '0);
          out_nxt.third_gate  = (rem_r[3] != '0);
          out_nxt.running     = on_r;
          for (int i = 0; i < 4; i++) begin
            if (rem_r[i] != '0) rem_nxt[i] = rem_r[i] - 16'd1;
          end
          outv_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= MODE_CV;
      tempo_r <= TEMPO_RST;
      cvz_r <= TEMPO_RST;
      timeout_r <= 24'd48000;
      pulse_r <= 16'd48;
      lfsr_r <= LFSR_SEED;
      on_r <= 1'b0;
      pc_r <= '0;
      period_r <= '0;
      minc_r <= PB'(TEMPO_RST);
      hist_r <= '0;
      outv_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        chance_r[i] <= 9'd256;
        hn_r[i] <= 5'd1;
        hd_r[i] <= 5'd1;
        draw_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        phase_r[i] <= '0;
        rem_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      tempo_r <= tempo_nxt;
      cvz_r <= cvz_nxt;
      timeout_r <= timeout_nxt;
      pulse_r <= pulse_nxt;
      lfsr_r <= lfsr_nxt;
      on_r <= on_nxt;
      pc_r <= pc_nxt;
      period_r <= period_nxt;
      minc_r <= minc_nxt;
      hist_r <= hist_nxt;
      outv_r <= outv_nxt;
      for (int i = 0; i < 3; i++) begin
        chance_r[i] <= chance_nxt[i];
        hn_r[i] <= hn_nxt[i];
        hd_r[i] <= hd_nxt[i];
        draw_r[i] <= draw_nxt[i];
      end
      for (int i = 0; i < 4; i++) begin
        phase_r[i] <= phase_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= num_nxt[i];
      den_r[i] <= den_nxt[i];
    end
    cv_r <= cv_nxt;
    edge_r <= edge_nxt;
    extm_r <= extm_nxt;
    ppqn_r <= ppqn_nxt;
    k_r <= k_nxt;
    pn_r <= pn_nxt;
    pd_r <= pd_nxt;
    mant_r <= mant_nxt;
    dvd_r <= dvd_nxt;
    drem_r <= drem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    dext_r <= dext_nxt;
    out_r <= out_nxt;
  end

endmodule

@@ dv/tb_polyrhythm_clock_generator.sv @@
`timescale 1ns / 1ps

module tb_polyrhythm_clock_generator;
  import prc_pkg::*;

  localparam longint unsigned PHASE_ONE  = 64'h1_0000_0000;
  localparam longint unsigned PHASE_MASK = 64'h0_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 220;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  prc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  prc_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  polyrhythm_clock_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // 2^(i/16) and 2^(i/256) in Q16
  longint unsigned octave_frac [16] = '{65536, 68438, 71468, 74632, 77936, 81386,
    84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515};
  longint unsigned fine_frac [16] = '{65536, 65714, 65892, 66071, 66250, 66429,
    66609, 66790, 66971, 67153, 67335, 67517, 67700, 67884, 68068, 68252};

  // Shadow registers
  logic [2:0]  sh_mode;
  logic [31:0] sh_tempo, sh_cvzero;
  logic [8:0]  sh_chance [3];
  logic [23:0] sh_timeout;
  logic [15:0] sh_pulse;

  // Shadow clock state
  longint unsigned phase [4];
  longint unsigned held_num [3], held_den [3];
  logic [7:0]  draw [3];
  logic [15:0] lfsr;
  logic [15:0] gate_left [4];
  logic        clock_run;
  logic [4:0]  pulse_seen;
  logic [23:0] period_ticks;
  longint unsigned beat_inc;
  logic [2:0]  level_hist;

  prc_out_t gate_queue [$];
  prc_in_t  pending [$];
  int errors = 0;

  task automatic report(string what, logic got, logic want);
    $display("MISMATCH %s: got %0b expected %0b at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic shadow_reset();
    sh_mode = MODE_CV; sh_tempo = TEMPO_RST; sh_cvzero = TEMPO_RST;
    for (int k = 0; k < 3; k++) begin
      sh_chance[k] = 9'd256; held_num[k] = 1; held_den[k] = 1; draw[k] = '0;
    end
    sh_timeout = 24'd48000; sh_pulse = 16'd48;
    for (int i = 0; i < 4; i++) begin
      phase[i] = 0; gate_left[i] = '0;
    end
    lfsr = LFSR_SEED; clock_run = 1'b0; pulse_seen = '0; period_ticks = '0;
    beat_inc = TEMPO_RST; level_hist = '0;
  endtask

  task automatic shadow_cfg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_MODE:    sh_mode = val[2:0];
      CFG_TEMPO:   sh_tempo = val;
      CFG_CVZERO:  sh_cvzero = val;
      CFG_CHANCE1: sh_chance[0] = val[8:0];
      CFG_CHANCE2: sh_chance[1] = val[8:0];
      CFG_CHANCE3: sh_chance[2] = val[8:0];
      CFG_TIMEOUT: sh_timeout = val[23:0];
      CFG_PULSE:   sh_pulse = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] step_lfsr();
    logic lsb;
    lsb = lfsr[0];
    lfsr = lfsr >> 1;
    if (lsb) lfsr = lfsr ^ LFSR_TAPS;
    return lfsr[7:0];
  endfunction

  function automatic longint unsigned cv_rate(logic [11:0] cv);
    logic [11:0] u;
    longint unsigned mant, v;
    u = cv ^ 12'h800;
    mant = (octave_frac[u[7:4]] * fine_frac[u[3:0]]) >> 16;
    v = (longint'(sh_cvzero) * mant) >> (24 - u[11:8]);
    return (v > PHASE_MASK) ? PHASE_MASK : v;
  endfunction

  // Advance the shadow clock by one tick and return its gates
  function automatic prc_out_t tick(prc_in_t it);
    longint unsigned nums [3], dens [3];
    longint unsigned pn, pd, inc, v;
    logic ext_edge, ext_mode;
    logic [4:0] ppqn;
    prc_out_t r;
    logic [4:0] rr [3], ll [3];
    rr = '{it.rhythm_first, it.rhythm_second, it.rhythm_third};
    ll = '{it.length_first, it.length_second, it.length_third};
    ext_edge = 1'b0;
    ext_mode = it.ext_connected && (sh_mode != MODE_CV);
    ppqn = 5'd24;
    if (it.reset_level && !level_hist[0])
      for (int i = 0; i < 4; i++) phase[i] = 0;
    if (it.toggle_level && !level_hist[1]) clock_run = ~clock_run;
    level_hist[1:0] = {it.toggle_level, it.reset_level};
    for (int k = 0; k < 3; k++) begin
      nums[k] = (rr[k] > 24) ? 24 : rr[k];
      dens[k] = (ll[k] < 1) ? 1 : ((ll[k] > 24) ? 24 : ll[k]);
    end
    if (it.ext_connected) begin
      if (sh_mode == MODE_CV) begin
        beat_inc = cv_rate(it.tempo_cv);
      end else begin
        ext_edge = it.ext_clock_level && !level_hist[2];
        level_hist[2] = it.ext_clock_level;
        if (ext_edge) clock_run = 1'b1;
        case (sh_mode)
          3'd1: ppqn = 5'd2;
          3'd2: ppqn = 5'd4;
          3'd3: ppqn = 5'd8;
          3'd4: ppqn = 5'd12;
          default: ppqn = 5'd24;
        endcase
      end
    end else begin
      beat_inc = sh_tempo;
    end
    if (clock_run) begin
      if (ext_mode) begin
        if (period_ticks != 24'hFFFFFF) period_ticks++;
        if (period_ticks > sh_timeout) clock_run = 1'b0;
        if (ext_edge) begin
          if (pulse_seen > 1) begin
            v = PHASE_ONE / (longint'(period_ticks) * ppqn);
            beat_inc = (v > PHASE_MASK) ? PHASE_MASK : v;
          end
          pulse_seen++;
          if (pulse_seen >= ppqn) pulse_seen = '0;
          period_ticks = '0;
        end
      end
      // Latch a new ratio only at the parent's downbeat
      for (int k = 0; k < 3; k++)
        if (nums[k] * held_den[k] != held_num[k] * dens[k] && phase[k] == 0) begin
          held_num[k] = nums[k]; held_den[k] = dens[k]; phase[k + 1] = 0;
        end
      phase[0] += beat_inc;
      pn = 1; pd = 1;
      for (int k = 0; k < 3; k++) begin
        pn *= held_num[k]; pd *= held_den[k];
        inc = beat_inc * pn / pd;
        if (inc > PHASE_ONE) inc = PHASE_ONE;
        phase[k + 1] += inc;
      end
      // Wrap, redraw chance, fire pulses
      for (int i = 0; i < 4; i++) begin
        if (phase[i] >= PHASE_ONE) begin
          phase[i] = 0;
          if (i > 0) draw[i - 1] = step_lfsr();
        end
        if (phase[i] == 0 && (i == 0 || draw[i - 1] < sh_chance[i - 1]))
          if (gate_left[i] < sh_pulse) gate_left[i] = sh_pulse;
      end
    end else begin
      for (int i = 0; i < 4; i++) phase[i] = 0;
    end
    r.master_gate = gate_left[0] != 0;
    r.first_gate  = gate_left[1] != 0;
    r.second_gate = gate_left[2] != 0;
    r.third_gate  = gate_left[3] != 0;
    for (int i = 0; i < 4; i++) if (gate_left[i] != 0) gate_left[i]--;
    r.running = clock_run;
    return r;
  endfunction

  // Wait draws: random gaps, with bursts of back-to-back traffic
  int drv_burst = 0, mon_burst = 0;
  function automatic int draw_wait(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 15);
  endfunction

  // Driver: feed pending transactions
  int drv_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) gate_queue.push_back(tick(in_data));
      if (!(in_valid && !in_ready)) begin
        if (drv_wait > 0) begin
          drv_wait--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_data <= pending.pop_front();
          in_valid <= 1'b1;
          drv_wait = draw_wait(drv_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each result
  int mon_wait = 0;
  always @(posedge clk) begin
    prc_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (gate_queue.size() == 0) begin
          $display("MISMATCH unexpected result at %0t", $realtime);
          errors++;
        end else begin
          want = gate_queue.pop_front();
          if (out_data.master_gate !== want.master_gate)
            report("master_gate", out_data.master_gate, want.master_gate);
          if (out_data.first_gate !== want.first_gate)
            report("first_gate", out_data.first_gate, want.first_gate);
          if (out_data.second_gate !== want.second_gate)
            report("second_gate", out_data.second_gate, want.second_gate);
          if (out_data.third_gate !== want.third_gate)
            report("third_gate", out_data.third_gate, want.third_gate);
          if (out_data.running !== want.running)
            report("running", out_data.running, want.running);
        end
        mon_wait = draw_wait(mon_burst);
      end
      if (mon_wait > 0) begin
        mon_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    shadow_cfg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || gate_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus generator levels
  logic lv_reset = 0, lv_toggle = 0, lv_con = 0;
  logic [4:0] cur_r [3] = '{1, 1, 1};
  logic [4:0] cur_l [3] = '{1, 1, 1};
  int ext_phase = 0;

  // Random ticks: knobs mostly steady, square-wave external clock of ext_per ticks
  task automatic queue_ticks(int n, int con_pct, int ext_per);
    prc_in_t it;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < 3) lv_reset = ~lv_reset;
      if ($urandom_range(0, 99) < 3) lv_toggle = ~lv_toggle;
      if ($urandom_range(0, 99) < 4) lv_con = ($urandom_range(0, 99) < con_pct);
      for (int k = 0; k < 3; k++)
        if ($urandom_range(0, 99) < 6) begin
          cur_r[k] = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
          cur_l[k] = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
        end
      ext_phase++;
      it.reset_level = lv_reset;
      it.toggle_level = lv_toggle;
      it.ext_connected = lv_con;
      it.ext_clock_level = ($urandom_range(0, 49) == 0) ? 1'($urandom)
                           : ((ext_phase % ext_per) < ext_per / 2);
      it.tempo_cv = 12'($urandom);
      it.rhythm_first = cur_r[0]; it.length_first = cur_l[0];
      it.rhythm_second = cur_r[1]; it.length_second = cur_l[1];
      it.rhythm_third = cur_r[2]; it.length_third = cur_l[2];
      pending.push_back(it);
    end
  endtask

  // Directed: toggle on, field extremes, reset edge
  task automatic queue_directed();
    prc_in_t it;
    for (int j = 0; j < 20; j++) begin
      it = '0;
      it.toggle_level = (j == 0) || (j == 14);
      it.reset_level = (j == 8);
      it.ext_connected = (j >= 4 && j < 8) || j == 18;
      it.ext_clock_level = j[0];
      it.tempo_cv = (j == 4) ? 12'h800 : ((j == 5) ? 12'h7FF : 12'(j * 37));
      it.rhythm_first  = (j < 10) ? 5'd31 : 5'd0;
      it.length_first  = (j < 10) ? 5'd0 : 5'd31;
      it.rhythm_second = (j % 3 == 0) ? 5'd24 : 5'd3;
      it.length_second = (j % 3 == 0) ? 5'd1 : 5'd24;
      it.rhythm_third  = (j % 4 == 0) ? 5'd31 : 5'd2;
      it.length_third  = (j % 4 == 0) ? 5'd31 : 5'd0;
      pending.push_back(it);
    end
    lv_toggle = 1'b0;
  endtask

  initial begin
    shadow_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: slow tempo, mostly external disconnected
    queue_directed();
    queue_ticks(80, 20, 10);
    drain();

    // Fastest tempo, shortest pulses, chance extremes
    cfg_write(CFG_TEMPO, 32'hFFFF_FFFF);
    cfg_write(CFG_PULSE, 32'd1);
    cfg_write(CFG_CHANCE1, 32'd0);
    cfg_write(CFG_CHANCE2, 32'd256);
    cfg_write(CFG_CHANCE3, 32'd511);
    queue_ticks(100, 0, 10);
    drain();

    // Moderate tempo, random chances
    cfg_write(CFG_TEMPO, 32'h1000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
    cfg_write(CFG_PULSE, $urandom_range(2, 6));
    cfg_write(CFG_CHANCE1, $urandom_range(0, 256));
    cfg_write(CFG_CHANCE2, $urandom_range(0, 256));
    cfg_write(CFG_CHANCE3, $urandom_range(0, 256));
    queue_ticks(120, 10, 10);
    drain();

    // CV tempo: saturating then moderate zero-volt rate
    cfg_write(CFG_MODE, 32'(MODE_CV));
    cfg_write(CFG_CVZERO, 32'hFFFF_FFFF);
    queue_ticks(60, 90, 10);
    drain();
    cfg_write(CFG_CVZERO, $urandom_range(32'h0080_0000, 32'h0800_0000));
    queue_ticks(80, 90, 10);
    drain();

    // External clock in every mode, including the unused codes
    for (int m = 1; m < 8; m++) begin
      cfg_write(CFG_MODE, 32'(m));
      cfg_write(CFG_TIMEOUT, (m == 1) ? 32'd0 : ((m == 7) ? 32'hFF_FFFF
                                         : $urandom_range(8, 60)));
      queue_ticks(40, 90, $urandom_range(3, 14));
      drain();
    end

    // Stalled master, endless pulses
    cfg_write(CFG_MODE, 32'(MODE_CV));
    cfg_write(CFG_TEMPO, 32'd0);
    cfg_write(CFG_PULSE, 32'h0000_FFFF);
    queue_ticks(60, 10, 10);
    drain();

    // No pulses at all
    cfg_write(CFG_PULSE, 32'd0);
    cfg_write(CFG_TEMPO, 32'h2000_0000);
    queue_ticks(50, 10, 10);
    drain();

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
